// File: src/double_ended_queue_macros.svh
// assertion macros for the double-ended queue checker
// no dependencies; included by the checker file only
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// File: src/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies
`default_nettype none

package deq_pkg;

    localparam int DEF_DEPTH      = 1024;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int MODE_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SIZE       = 3'd7;

    // status of the request held in the read stage
    typedef struct packed {
        logic rd;
        logic err;
    } t_s1_info;

endpackage

`default_nettype wire

// File: src/deq_mem.sv
// word storage: one write port, one read port, registered read data
// depends on nothing but its parameters
`default_nettype none

module deq_mem #(
    parameter int DEPTH      = 1024,
    parameter int WORD_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WORD_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/deq_ctrl.sv
// pointer control: head index, occupancy, memory addressing, read stage
// depends on deq_pkg
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int WORD_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [deq_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [deq_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_we,
    output logic      [AW-1:0]                 o_waddr,
    output logic      [WORD_WIDTH-1:0]         o_wdata,
    output logic                               o_re,
    output logic      [AW-1:0]                 o_raddr,
    output logic                               o_s1_valid,
    output deq_pkg::t_s1_info                  o_s1_info,
    output logic      [CW-1:0]                 o_s1_count,
    input  wire logic                          i_s1_adv
);

    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_occ, n_occ;
    logic          r_s1_valid;
    deq_pkg::t_s1_info r_s1_info, n_s1_info;
    logic [CW-1:0] r_s1_count;

    logic          accept;
    logic          full, empty;
    logic [CW:0]   sum_back, sum_last;
    logic [CW:0]   wrap_back, wrap_last;
    logic [AW-1:0] head_dec, head_inc;
    logic [63:0]   value_x;

    assign o_ready = !r_s1_valid || i_s1_adv;
    assign accept  = i_valid && o_ready;
    assign full    = (r_occ == FULL_C);
    assign empty   = (r_occ == '0);

    // slot after the last word, and the last word itself
    assign sum_back  = (CW + 1)'(r_head) + (CW + 1)'(r_occ);
    assign sum_last  = sum_back - (CW + 1)'(1);
    assign wrap_back = (sum_back >= DEPTH_X) ? sum_back - DEPTH_X : sum_back;
    assign wrap_last = (sum_last >= DEPTH_X) ? sum_last - DEPTH_X : sum_last;
    assign head_dec  = (r_head == '0) ? LAST_C : r_head - AW'(1);
    assign head_inc  = (r_head == LAST_C) ? '0 : r_head + AW'(1);

    assign value_x = {32'd0, i_value};
    assign o_wdata = value_x[WORD_WIDTH-1:0];

    always_comb begin
        n_head    = r_head;
        n_occ     = r_occ;
        n_s1_info = '{rd: 1'b0, err: 1'b0};
        o_we      = 1'b0;
        o_waddr   = wrap_back[AW-1:0];
        o_re      = 1'b0;
        o_raddr   = r_head;
        case (i_mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    n_s1_info.err = 1'b1;
                end else begin
                    o_we  = accept;
                    n_occ = r_occ + CW'(1);
                    if (i_mode == deq_pkg::MODE_PUSH_FRONT) begin
                        n_head  = head_dec;
                        o_waddr = head_dec;
                    end
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK,
            deq_pkg::MODE_PEEK_FRONT, deq_pkg::MODE_PEEK_BACK: begin
                if (empty) begin
                    n_s1_info.err = 1'b1;
                end else begin
                    o_re         = accept;
                    n_s1_info.rd = 1'b1;
                    if (i_mode == deq_pkg::MODE_POP_BACK ||
                        i_mode == deq_pkg::MODE_PEEK_BACK) begin
                        o_raddr = wrap_last[AW-1:0];
                    end
                    if (i_mode == deq_pkg::MODE_POP_FRONT) begin
                        n_head = head_inc;
                        n_occ  = r_occ - CW'(1);
                    end else if (i_mode == deq_pkg::MODE_POP_BACK) begin
                        n_occ = r_occ - CW'(1);
                    end
                end
            end
            deq_pkg::MODE_CLEAR: begin
                n_head = '0;
                n_occ  = '0;
            end
            default: begin
                // size query leaves the state alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_occ      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head     <= n_head;
                r_occ      <= n_occ;
                r_s1_valid <= 1'b1;
            end else if (i_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info  <= n_s1_info;
            r_s1_count <= n_occ;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_info  = r_s1_info;
    assign o_s1_count = r_s1_count;

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// Bounded double-ended queue of signed words kept in a ring buffer.
//
// Input stream: one request per beat. s_axis_tuser carries the operation
// (push front/back, pop front/back, peek front/back, clear, size query),
// s_axis_tdata the word to push. Output stream: one result per request,
// in order: the word read (zero for push, clear, size query or error),
// the occupancy after the request, and an error flag in m_axis_tuser.
//
// The synchronous storage read and the read stage load at the accepting edge,
// and the output register loads when the read stage advances; the result then
// shows on the master side. Throughput is one request per cycle while the
// receiver keeps up; the read stage and the output register each hold
// one request, so a new request is taken while a finished result still waits.
// When the receiver stalls, the result holds, the read stage fills, and
// s_axis_tready drops until the output register drains.
// Reset clears the head index, the occupancy and both valid flags; the
// storage is not cleared, since only pushed entries are ever read.
// depends on deq_pkg, deq_ctrl, deq_mem
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEF_WORD_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] value
    input  wire logic [deq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] mode
    input  wire logic [deq_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] data, [42:32] count, [47:43] zero
    output logic      [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] error
    output logic                                   m_axis_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [WORD_WIDTH-1:0] wdata, rdata;
    logic                  s1_valid, s1_adv;
    deq_pkg::t_s1_info     s1_info;
    logic [CW-1:0]         s1_count;

    logic                          r_out_valid;
    logic [deq_pkg::DATA_W-1:0]    r_out_data, n_out_data;
    logic [deq_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_err;
    logic signed [63:0]            rdata_x;
    logic [63:0]                   count_x;

    deq_ctrl #(
        .DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH), .AW(AW), .CW(CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_value    (s_axis_tdata[deq_pkg::VALUE_W-1:0]),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .o_s1_valid (s1_valid),
        .o_s1_info  (s1_info),
        .o_s1_count (s1_count),
        .i_s1_adv   (s1_adv)
    );

    deq_mem #(
        .DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH), .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s1_adv  = s1_valid && (!r_out_valid || m_axis_tready);
    assign rdata_x = 64'($signed(rdata));
    assign count_x = 64'(s1_count);
    assign n_out_data = (s1_info.rd && !s1_info.err) ? rdata_x[deq_pkg::DATA_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data  <= n_out_data;
            r_out_count <= count_x[deq_pkg::COUNT_W-1:0];
            r_out_err   <= s1_info.err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_data};
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

// File: src/deq_chk.sv
// port-level checker for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_macros.svh
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_chk #(
    parameter int DEPTH = deq_pkg::DEF_DEPTH
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tuser
);

    logic [31:0] out_count;
    logic        in_req;

    assign out_count = 32'(m_axis_tdata[42:32]);
    assign in_req    = s_axis_tvalid && s_axis_tready;

    // a stalled result keeps its value
    `DEQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an errored request never returns a word
    `DEQ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'd0)

    // occupancy stays within the ring
    `DEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, m_axis_tvalid, (out_count <= 32'(DEPTH)) || (DEPTH > 1024))

    // nothing leaves the block right after reset
    `DEQ_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !m_axis_tvalid && !$past(in_req))

endmodule

bind double_ended_queue deq_chk #(.DEPTH(DEPTH)) u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/deq_tb_pkg.sv
// shadow model of the double-ended queue: predicts one result per request and checks
// the results coming out of the block in order
// depends on deq_pkg
`timescale 1ns / 1ps

package deq_tb_pkg;

    import deq_pkg::*;

    localparam int SLOTS  = DEF_DEPTH;
    localparam int SLOT_W = $clog2(DEF_DEPTH);

    typedef struct {
        logic [DATA_W-1:0]  data;
        logic               error;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    class deque_shadow;
        logic [DEF_WORD_WIDTH-1:0] words [SLOTS];
        logic [SLOT_W-1:0]         head;
        logic [COUNT_W-1:0]        occupancy;
        deq_result_t               pending_results [$];
        int unsigned               failures;

        function new();
            head      = '0;
            occupancy = '0;
            failures  = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // update the shadow state for an accepted request and queue its result
        function void note_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
            deq_result_t       r;
            logic [SLOT_W-1:0] idx;
            r.data  = '0;
            r.error = 1'b0;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (occupancy == SLOTS) begin
                        r.error = 1'b1;
                    end else begin
                        if (mode == MODE_PUSH_FRONT) begin
                            head = head - 1'b1;
                            idx  = head;
                        end else begin
                            idx = head + occupancy[SLOT_W-1:0];
                        end
                        words[idx] = value;
                        occupancy  = occupancy + 1'b1;
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                    if (occupancy == 0) begin
                        r.error = 1'b1;
                    end else begin
                        if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
                            idx = head;
                        end else begin
                            idx = head + occupancy[SLOT_W-1:0] - 1'b1;
                        end
                        r.data = words[idx];
                        if (mode == MODE_POP_FRONT) begin
                            head      = head + 1'b1;
                            occupancy = occupancy - 1'b1;
                        end else if (mode == MODE_POP_BACK) begin
                            occupancy = occupancy - 1'b1;
                        end
                    end
                end
                MODE_CLEAR: begin
                    head      = '0;
                    occupancy = '0;
                end
                default: begin
                    // size query leaves the state alone
                end
            endcase
            r.count = occupancy;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic error,
                                   logic [COUNT_W-1:0] count);
            deq_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: data %0d error %0d count %0d",
                       $signed(data), error, count);
                failures++;
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (data !== want.data) begin
                $error("data mismatch: expected %0d, actual %0d",
                       $signed(want.data), $signed(data));
                failures++;
            end
            if (error !== want.error) begin
                $error("error mismatch: expected %0d, actual %0d", want.error, error);
                failures++;
            end
            if (count !== want.count) begin
                $error("count mismatch: expected %0d, actual %0d", want.count, count);
                failures++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb_top.sv
// top of the double-ended queue testbench: clock, reset, request driver, result
// receiver with random stalls, and the run watchdog
// depends on deq_pkg, deq_tb_pkg and the double_ended_queue rtl
`timescale 1ns / 1ps

module tb_top;

    import deq_pkg::*;
    import deq_tb_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 80;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] value
    logic [MODE_W-1:0]      s_axis_tuser;   // [2:0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] data, [42:32] count, [47:43] zero
    logic                   m_axis_tuser;   // [0] error

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          rx_hold_request;
    int unsigned cycle_count;

    deque_shadow shadow = new();

    double_ended_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_request(mode, value);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(int push_pct, int clear_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        if (roll >= 100 - clear_pct) return MODE_CLEAR;
        case ($urandom_range(0, 4))
            0: return MODE_POP_FRONT;
            1: return MODE_POP_BACK;
            2: return MODE_PEEK_FRONT;
            3: return MODE_PEEK_BACK;
            default: return MODE_SIZE;
        endcase
    endfunction

    // result receiver; a hold request parks tready low for a long stretch
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            shadow.check_result(m_axis_tdata[DATA_W-1:0], m_axis_tuser,
                                m_axis_tdata[DATA_W+COUNT_W-1:DATA_W]);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        rx_hold_request = 1'b0;
        tx_idle_pct     = 32;
        rx_idle_pct     = 51;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: every read errors, size reports zero
        send_request(MODE_POP_FRONT, 32'h1234_5678);
        send_request(MODE_POP_BACK, 32'hFFFF_FFFF);
        send_request(MODE_PEEK_FRONT, 32'h0);
        send_request(MODE_PEEK_BACK, 32'h8000_0000);
        send_request(MODE_SIZE, 32'h7FFF_FFFF);
        // extremes of the word; front push from head zero wraps the index
        send_request(MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(MODE_PUSH_BACK, 32'h8000_0000);
        send_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(MODE_PUSH_FRONT, 32'h0000_0000);
        send_request(MODE_SIZE, 32'h0);
        send_request(MODE_PEEK_FRONT, 32'hFFFF_FFFF);
        send_request(MODE_PEEK_BACK, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_SIZE, 32'h0);
        send_request(MODE_CLEAR, 32'hFFFF_FFFF);
        send_request(MODE_PEEK_FRONT, 32'h0);
        send_request(MODE_PUSH_FRONT, 32'h5555_5555);
        send_request(MODE_PUSH_BACK, 32'hAAAA_AAAA);
        send_request(MODE_POP_BACK, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        wait_drained();

        repeat (50) send_request(pick_mode(45, 3), $urandom());
        wait_drained();

        tx_idle_pct = 51;
        rx_idle_pct = 32;
        repeat (50) send_request(pick_mode(45, 3), $urandom());
        wait_drained();

        // no idling: fill to capacity behind a long receiver stall, then overflow
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 1'b1;
        while (shadow.occupancy < SLOTS) send_request(pick_mode(100, 0), $urandom());
        repeat (4) send_request($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                                $urandom());
        send_request(MODE_PEEK_FRONT, $urandom());
        send_request(MODE_PEEK_BACK, $urandom());
        send_request(MODE_SIZE, $urandom());
        repeat (30) send_request(pick_mode(10, 0), $urandom());
        send_request(MODE_CLEAR, $urandom());
        repeat (20) send_request(pick_mode(45, 3), $urandom());
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/deq_pkg.sv
src/deq_mem.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
src/deq_chk.sv
tb/sv/deq_tb_pkg.sv
tb/sv/tb_top.sv
